### rtl/fmh_pkg.sv
// Shared types, constants and helper functions for the fmix64 key hash and combine block.
`default_nettype none

package fmh_pkg;

	// Operation codes
	localparam logic OP_HASH    = 1'b0;
	localparam logic OP_COMBINE = 1'b1;

	// Key kinds
	localparam logic [2:0] KIND_INT8    = 3'd0;
	localparam logic [2:0] KIND_INT16   = 3'd1;
	localparam logic [2:0] KIND_INT32   = 3'd2;
	localparam logic [2:0] KIND_INT64   = 3'd3;
	localparam logic [2:0] KIND_FLOAT32 = 3'd4;
	localparam logic [2:0] KIND_FLOAT64 = 3'd5;

	// Configuration register indexes
	localparam logic [1:0] REG_SEED    = 2'd0;
	localparam logic [1:0] REG_MUL_ONE = 2'd1;
	localparam logic [1:0] REG_MUL_TWO = 2'd2;
	localparam logic [1:0] REG_GOLDEN  = 2'd3;

	// Register reset values
	localparam logic [63:0] RST_SEED    = 64'h0000_0000_0000_0000;
	localparam logic [63:0] RST_MUL_ONE = 64'hff51_afd7_ed55_8ccd;
	localparam logic [63:0] RST_MUL_TWO = 64'hc4ce_b9fe_1a85_ec53;
	localparam logic [63:0] RST_GOLDEN  = 64'h9e37_79b9_7f4a_7c15;

	localparam int unsigned MIX_SHIFT     = 33;
	localparam int unsigned COMBINE_SHL   = 6;
	localparam int unsigned COMBINE_SHR   = 2;
	localparam int unsigned HALF_W        = 32;

	typedef struct packed {
		logic        operation;
		logic [2:0]  key_kind;
		logic [63:0] first_word;
		logic [63:0] second_word;
		logic        last_in;
	} fmh_in_t;

	typedef struct packed {
		logic [63:0] hash_value;
		logic        last_out;
	} fmh_out_t;

	// Zero-extend the key to 64 bits by kind; fold both float zeros to all zeros.
	function automatic logic [63:0] widen_key(input logic [2:0] kind, input logic [63:0] raw);
		logic [63:0] k;
		case (kind)
			KIND_INT8:    k = {56'b0, raw[7:0]};
			KIND_INT16:   k = {48'b0, raw[15:0]};
			KIND_INT32:   k = {32'b0, raw[31:0]};
			KIND_FLOAT32: k = (raw[30:0] == 31'b0) ? 64'b0 : {32'b0, raw[31:0]};
			KIND_FLOAT64: k = (raw[62:0] == 63'b0) ? 64'b0 : raw;
			default:      k = raw;
		endcase
		return k;
	endfunction

	function automatic logic [63:0] xorshift(input logic [63:0] x);
		return x ^ (x >> MIX_SHIFT);
	endfunction

endpackage

`default_nettype wire

### rtl/fmix64_key_hash_and_combine.sv
// Top level of the fmix64 key hash and hash combine pipeline.
`default_nettype none

// One item enters per clock cycle; an accepted item passes through the
// stage registers in order, and its result, marked by done, is shown from
// the last of them. The two 64-bit wrapping multiplies of fmix64 are each
// cut into a stage of three 32-bit partial products and a stage that sums
// them and applies the xor-shift. busy stays low, since the pipeline never
// stalls: done is a one-cycle strobe and the receiver must take the result
// in that cycle. Configuration writes are always ready and take effect at
// the next item; write only while no item is in flight.
module fmix64_key_hash_and_combine
	import fmh_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// item side
	input  wire logic        start,
	output logic             busy,
	input  wire fmh_in_t     cmd,
	// result side
	output logic             done,
	output fmh_out_t         result,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	// Configuration registers
	logic [63:0] seed_q, mul_one_q, mul_two_q, golden_q;

	logic accept;

	// Stage registers
	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic        last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;
	logic        op_s1;
	logic [63:0] x_s1;   // hash: premixed key; combine: a
	logic [63:0] p_s1;   // combine: b + golden
	logic [63:0] q_s1;   // combine: (a << 6) + (a >> 2)
	logic [63:0] x_s2;
	logic [63:0] ll_s3;
	logic [31:0] lh_s3, hl_s3;
	logic [63:0] x_s4;
	logic [63:0] ll_s5;
	logic [31:0] lh_s5, hl_s5;
	logic [63:0] hash_s6;

	logic [63:0] s2_pre;
	logic [63:0] s4_sum;
	logic [63:0] s6_sum;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Hold the constants; load one on each completed write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q    <= RST_SEED;
			mul_one_q <= RST_MUL_ONE;
			mul_two_q <= RST_MUL_TWO;
			golden_q  <= RST_GOLDEN;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SEED:    seed_q    <= cfg_data;
				REG_MUL_ONE: mul_one_q <= cfg_data;
				REG_MUL_TWO: mul_two_q <= cfg_data;
				REG_GOLDEN:  golden_q  <= cfg_data;
				default:     ;
			endcase
		end
	end

	// Valid bits advance every cycle; nothing ever stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage 2 logic: finish the combine premix, then the first xor-shift.
	assign s2_pre = (op_s1 == OP_COMBINE) ? (x_s1 ^ (p_s1 + q_s1)) : x_s1;

	// Stages 4 and 6: assemble the low 64 bits of the product from its parts.
	assign s4_sum = ll_s3 + {lh_s3 + hl_s3, 32'b0};
	assign s6_sum = ll_s5 + {lh_s5 + hl_s5, 32'b0};

	// Payload registers
	always_ff @(posedge clk) begin
		// Stage 1: widen the key and premix it, or start the combine sum.
		op_s1   <= cmd.operation;
		last_s1 <= cmd.last_in;
		if (cmd.operation == OP_COMBINE) begin
			x_s1 <= cmd.first_word;
		end else begin
			x_s1 <= widen_key(cmd.key_kind, cmd.first_word) ^ (seed_q + golden_q);
		end
		p_s1 <= cmd.second_word + golden_q;
		q_s1 <= (cmd.first_word << COMBINE_SHL) + (cmd.first_word >> COMBINE_SHR);

		// Stage 2
		x_s2    <= xorshift(s2_pre);
		last_s2 <= last_s1;

		// Stage 3: partial products of the first multiply
		ll_s3   <= 64'(x_s2[HALF_W-1:0]) * 64'(mul_one_q[HALF_W-1:0]);
		lh_s3   <= 32'(x_s2[HALF_W-1:0] * mul_one_q[63:HALF_W]);
		hl_s3   <= 32'(x_s2[63:HALF_W] * mul_one_q[HALF_W-1:0]);
		last_s3 <= last_s2;

		// Stage 4
		x_s4    <= xorshift(s4_sum);
		last_s4 <= last_s3;

		// Stage 5: partial products of the second multiply
		ll_s5   <= 64'(x_s4[HALF_W-1:0]) * 64'(mul_two_q[HALF_W-1:0]);
		lh_s5   <= 32'(x_s4[HALF_W-1:0] * mul_two_q[63:HALF_W]);
		hl_s5   <= 32'(x_s4[63:HALF_W] * mul_two_q[HALF_W-1:0]);
		last_s5 <= last_s4;

		// Stage 6: final sum and xor-shift into the result register
		hash_s6 <= xorshift(s6_sum);
		last_s6 <= last_s5;
	end

	assign done              = v_s6;
	assign result.hash_value = hash_s6;
	assign result.last_out   = last_s6;

endmodule

`default_nettype wire

### rtl/fmh_checker.sv
// Port-level checker for the fmix64 hash pipeline, bound to the top level.
`default_nettype none

module fmh_checker
	import fmh_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire fmh_in_t     cmd,
	input wire logic        done,
	input wire fmh_out_t    result,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready
);

	// Every result traces back to an item that the pipeline took.
	a_done_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 6))
		else $error("result without a matching item");

	// Every item taken yields its result, with its batch mark.
	a_item_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##6 (done && result.last_out == $past(cmd.last_in, 6)))
		else $error("item lost or batch mark changed");

	// The pipeline never pushes back on items.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	// Configuration writes are never held off.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind fmix64_key_hash_and_combine fmh_checker u_fmh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.cmd       (cmd),
	.done      (done),
	.result    (result),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

`default_nettype wire

### test/fmix64_key_hash_and_combine_tb.sv
// Testbench for the fmix64 key hash and combine block, checked against a local predictor.
`default_nettype none

module fmix64_key_hash_and_combine_tb
	import fmh_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// Generous bound on the whole run, covering the slowest phase plus drains.
	localparam int unsigned CYCLE_LIMIT = 200_000;
	// Pipeline depth is six; allow a few cycles of slack after the last result.
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned ITEMS_PER_SETTING = 110;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	fmh_in_t     cmd;
	logic        done;
	fmh_out_t    result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;

	fmix64_key_hash_and_combine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Local copy of the four configuration registers, tracked on every
	// accepted write.
	logic [63:0] hash_seed;
	logic [63:0] mul_one;
	logic [63:0] mul_two;
	logic [63:0] golden;

	// Results predicted for accepted items, oldest first.
	fmh_out_t    pending_hashes[$];
	int unsigned mismatch_count;
	int unsigned cycle_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Abort a hung run.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			pending_hashes.size());
		$display("** fmix64_key_hash_and_combine: FAILED **");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Murmur3 finalizer with the multipliers currently programmed.
	function automatic logic [63:0] murmur_finalize(input logic [63:0] v);
		logic [63:0] x;
		x = v ^ (v >> MIX_SHIFT);
		x = x * mul_one;
		x = x ^ (x >> MIX_SHIFT);
		x = x * mul_two;
		return x ^ (x >> MIX_SHIFT);
	endfunction

	// Widen a raw key by its kind; both signed float zeros collapse to zero.
	// Kinds six and seven fall through to the full 64-bit key.
	function automatic logic [63:0] key_to_word(input logic [2:0] kind, input logic [63:0] raw);
		logic [63:0] k;
		k = raw;
		case (kind)
			KIND_INT8:    k = raw & 64'h0000_0000_0000_00ff;
			KIND_INT16:   k = raw & 64'h0000_0000_0000_ffff;
			KIND_INT32:   k = raw & 64'h0000_0000_ffff_ffff;
			KIND_FLOAT32: begin
				k = raw & 64'h0000_0000_ffff_ffff;
				if (k[30:0] == '0)
					k = '0;
			end
			KIND_FLOAT64: begin
				if (raw[62:0] == '0)
					k = '0;
			end
			default: k = raw;
		endcase
		return k;
	endfunction

	function automatic fmh_out_t predict_hash(input fmh_in_t c);
		fmh_out_t    r;
		logic [63:0] mixed_b;
		if (c.operation == OP_HASH) begin
			r.hash_value = murmur_finalize(key_to_word(c.key_kind, c.first_word)
				^ (hash_seed + golden));
		end else begin
			// Seed and key kind play no part in a combine.
			mixed_b = c.second_word + golden + (c.first_word << COMBINE_SHL)
				+ (c.first_word >> COMBINE_SHR);
			r.hash_value = murmur_finalize(c.first_word ^ mixed_b);
		end
		r.last_out = c.last_in;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result checking: done is a one-cycle strobe, so take it at every edge.
	// ------------------------------------------------------------------

	task automatic note_mismatch(input string field, input logic [63:0] want,
		input logic [63:0] got);
		mismatch_count++;
		$display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
	endtask

	always @(posedge clk) begin
		fmh_out_t want;
		if (arst_n && done) begin
			if (pending_hashes.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result, expected none, got %h last %b",
					$realtime, result.hash_value, result.last_out);
			end else begin
				want = pending_hashes.pop_front();
				if (result.hash_value !== want.hash_value)
					note_mismatch("hash_value", want.hash_value, result.hash_value);
				if (result.last_out !== want.last_out)
					note_mismatch("last_out", 64'(want.last_out), 64'(result.last_out));
			end
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Present one item, idling first with the given chance per cycle. Hold
	// start high on return so back-to-back items stream one per cycle.
	task automatic send_item(input fmh_in_t item, input int unsigned gap_pct);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd   <= item;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_hashes.push_back(predict_hash(item));
	endtask

	// Drop start and wait until every predicted result has come back.
	task automatic drain_pipeline();
		start <= 1'b0;
		while (pending_hashes.size() != 0)
			@(posedge clk);
	endtask

	// Write one register; cfg_valid stays high for a following write.
	task automatic write_reg(input logic [1:0] index, input logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (index)
			REG_SEED:    hash_seed = value;
			REG_MUL_ONE: mul_one   = value;
			REG_MUL_TWO: mul_two   = value;
			REG_GOLDEN:  golden    = value;
			default: ;
		endcase
	endtask

	// Program all four registers; only call with the pipeline drained.
	task automatic load_config(input logic [63:0] s, input logic [63:0] m1,
		input logic [63:0] m2, input logic [63:0] g);
		write_reg(REG_SEED, s);
		write_reg(REG_MUL_ONE, m1);
		write_reg(REG_MUL_TWO, m2);
		write_reg(REG_GOLDEN, g);
		cfg_valid <= 1'b0;
	endtask

	function automatic fmh_in_t make_item(input logic op, input logic [2:0] kind,
		input logic [63:0] a, input logic [63:0] b, input logic last);
		fmh_in_t c;
		c.operation   = op;
		c.key_kind    = kind;
		c.first_word  = a;
		c.second_word = b;
		c.last_in     = last;
		return c;
	endfunction

	// Random word biased toward extremes, small 16-bit values and the two float
	// zero patterns, with random garbage left in the bits the kind should mask.
	function automatic logic [63:0] random_word();
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(9))
			0: w = '0;
			1: w = '1;
			2: w[30:0] = '0;
			3: w[62:0] = '0;
			4: w = w & 64'h0000_0000_0000_ffff;
			default: ;
		endcase
		return w;
	endfunction

	function automatic fmh_in_t random_item();
		return make_item(1'($urandom_range(1)), 3'($urandom_range(7)), random_word(),
			random_word(), 1'($urandom_range(1)));
	endfunction

	function automatic logic [63:0] random_reg_value();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(7))
			0: v = '0;
			1: v = '1;
			2: v = 64'd1;
			default: ;
		endcase
		return v;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset constants: every key kind, both float zeros, masking of upper
	// key bits, NaN passthrough, and combine at the word extremes.
	task automatic test_reset_config_directed();
		logic [63:0] ones;
		ones = '1;
		for (int k = 0; k < 8; k++)
			send_item(make_item(OP_HASH, 3'(k), ones, 64'h0, 1'(k[0])), 0);
		send_item(make_item(OP_HASH, KIND_INT8, 64'h0, ones, 1'b0), 0);
		send_item(make_item(OP_HASH, KIND_INT64, 64'h0, 64'h0, 1'b1), 0);
		// float32 negative zero with junk above bit 31
		send_item(make_item(OP_HASH, KIND_FLOAT32, 64'hdead_beef_8000_0000, 64'h0, 1'b0), 0);
		send_item(make_item(OP_HASH, KIND_FLOAT32, 64'hffff_ffff_0000_0000, 64'h0, 1'b1), 0);
		// float32 NaN and smallest subnormal stay as they are
		send_item(make_item(OP_HASH, KIND_FLOAT32, 64'h0000_0000_7fc0_0001, 64'h0, 1'b0), 0);
		send_item(make_item(OP_HASH, KIND_FLOAT32, 64'h0000_0000_0000_0001, 64'h0, 1'b0), 0);
		send_item(make_item(OP_HASH, KIND_FLOAT64, 64'h8000_0000_0000_0000, 64'h0, 1'b1), 0);
		send_item(make_item(OP_HASH, KIND_FLOAT64, 64'h0, 64'h0, 1'b0), 0);
		send_item(make_item(OP_HASH, KIND_FLOAT64, 64'h8000_0000_0000_0001, 64'h0, 1'b0), 0);
		send_item(make_item(OP_HASH, KIND_FLOAT64, 64'h7ff8_0000_0000_0000, 64'h0, 1'b1), 0);
		send_item(make_item(OP_COMBINE, KIND_INT8, 64'h0, 64'h0, 1'b0), 0);
		send_item(make_item(OP_COMBINE, KIND_FLOAT64, ones, ones, 1'b1), 0);
		send_item(make_item(OP_COMBINE, KIND_INT32, ones, 64'h0, 1'b0), 0);
		send_item(make_item(OP_COMBINE, 3'd7, 64'h0, ones, 1'b1), 0);
		drain_pipeline();
	endtask

	// Register extremes: all zeros, all ones, and unit multipliers.
	task automatic test_config_extremes();
		logic [63:0] ones;
		ones = '1;
		load_config('0, '0, '0, '0);
		repeat (6) send_item(random_item(), 0);
		drain_pipeline();
		load_config(ones, ones, ones, ones);
		repeat (6) send_item(random_item(), 0);
		drain_pipeline();
		load_config(ones, 64'd1, 64'd1, '0);
		repeat (6) send_item(random_item(), 0);
		drain_pipeline();
	endtask

	// Random stream under several random register settings.
	task automatic test_random_stream(input int unsigned gap_pct, input int unsigned count);
		int unsigned sent;
		sent = 0;
		while (sent < count) begin
			load_config(random_reg_value(), random_reg_value(), random_reg_value(),
				random_reg_value());
			for (int i = 0; i < ITEMS_PER_SETTING && sent < count; i++) begin
				send_item(random_item(), gap_pct);
				sent++;
			end
			drain_pipeline();
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		cmd       <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_SEED;
		cfg_data  <= '0;
		cycle_count    = 0;
		mismatch_count = 0;
		hash_seed = RST_SEED;
		mul_one   = RST_MUL_ONE;
		mul_two   = RST_MUL_TWO;
		golden    = RST_GOLDEN;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_config_directed();
		test_config_extremes();
		// sender idles rarely, then often, then never
		test_random_stream(11, 350);
		test_random_stream(70, 350);
		test_random_stream(0, 350);

		// Catch any stray result beyond the last expected one.
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("** fmix64_key_hash_and_combine: PASSED **");
		end else begin
			$display("** fmix64_key_hash_and_combine: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire
